/* rtl/lzss_pkg.sv */
// Shared types and constants for the LZSS stream decompressor.
package lzss_pkg;

  typedef enum logic [1:0] {
    CMD_FEED  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_BYTE    = 2'd0,
    ST_END     = 2'd1,
    ST_REFUSED = 2'd2
  } status_code_t;

  localparam logic [11:0] OFS_END  = 12'hFFF;
  localparam logic [3:0]  NIB_EXT  = 4'hF;
  localparam logic [15:0] LEN_BIAS = 16'd3;
  localparam logic [15:0] LEN_EXT  = 16'd18;
  localparam logic [3:0]  FLAG_CNT = 4'd8;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
  } res_t;

  // Request from the parser to the window stage for one result beat.
  typedef struct packed {
    logic       valid;
    logic       literal;
    logic       fwd;
    logic       rd_ok;
    logic [1:0] status;
    logic [7:0] lit_byte;
  } win_req_t;

endpackage

/* rtl/lzss_parse.sv */
// Token parser, copy sequencer and window address generation.
module lzss_parse #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int AW = $clog2(WINDOW_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lzss_pkg::cmd_t    cmd,
  output lzss_pkg::win_req_t req,
  output logic [AW-1:0]     rd_addr,
  output logic [AW-1:0]     wr_addr
);

  typedef enum logic [2:0] {
    PH_CTRL = 3'd0,
    PH_ITEM = 3'd1,
    PH_REF2 = 3'd2,
    PH_EXT1 = 3'd3,
    PH_EXT2 = 3'd4
  } phase_t;

  localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(WINDOW_DEPTH);

  phase_t      phase, phase_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [3:0]  flags_left, flags_left_next;
  logic [7:0]  first_ref, first_ref_next;
  logic [7:0]  second_ref, second_ref_next;
  logic [6:0]  ext_low, ext_low_next;
  logic [15:0] copy_remaining, copy_remaining_next;
  logic [11:0] copy_distance, copy_distance_next;
  logic        stream_ended, stream_ended_next;
  logic [AW-1:0] wp, wp_next;
  logic        wrapped, wrapped_next;
  logic        prev_emit, prev_emit_next;

  logic [AW:0]   src_raw;
  logic [AW-1:0] src;
  logic          emit;
  logic          finish;
  logic [15:0]   len;
  logic [7:0]    sec;
  logic [11:0]   offset;
  logic [7:0]    b;
  lzss_pkg::win_req_t req_v;

  assign b = cmd.data_byte;

  // Source address: wp - distance - 1, modulo the window depth.
  always_comb begin
    src_raw = {1'b0, wp} - (AW+1)'(copy_distance) - (AW+1)'(1);
    if (src_raw[AW]) begin
      src_raw = src_raw + DEPTH_W;
    end
    src = src_raw[AW-1:0];
  end

  assign sec    = (phase == PH_REF2) ? b : second_ref;
  assign offset = {first_ref, sec[7:4]};

  always_comb begin
    phase_next          = phase;
    flag_bits_next      = flag_bits;
    flags_left_next     = flags_left;
    first_ref_next      = first_ref;
    second_ref_next     = second_ref;
    ext_low_next        = ext_low;
    copy_remaining_next = copy_remaining;
    copy_distance_next  = copy_distance;
    stream_ended_next   = stream_ended;
    wrapped_next        = wrapped;
    emit                = 1'b0;
    finish              = 1'b0;
    len                 = '0;
    req_v               = '0;
    req_v.lit_byte      = b;
    req_v.status        = lzss_pkg::ST_BYTE;
    req_v.fwd           = prev_emit && (copy_distance == '0);
    req_v.rd_ok         = wrapped || (src < wp);

    if (accept) begin
      unique case (cmd.command)
        lzss_pkg::CMD_START: begin
          phase_next          = PH_CTRL;
          flag_bits_next      = '0;
          flags_left_next     = '0;
          first_ref_next      = '0;
          second_ref_next     = '0;
          ext_low_next        = '0;
          copy_remaining_next = '0;
          copy_distance_next  = '0;
          stream_ended_next   = 1'b0;
        end
        lzss_pkg::CMD_TICK: begin
          if (copy_remaining != '0) begin
            emit                = 1'b1;
            req_v.valid         = 1'b1;
            copy_remaining_next = copy_remaining - 16'd1;
          end
        end
        lzss_pkg::CMD_FEED: begin
          if (stream_ended || copy_remaining != '0) begin
            req_v.valid  = 1'b1;
            req_v.status = lzss_pkg::ST_REFUSED;
          end else begin
            unique case (phase)
              PH_ITEM: begin
                flag_bits_next  = {1'b0, flag_bits[7:1]};
                flags_left_next = (flags_left != '0) ? flags_left - 4'd1 : '0;
                if (flag_bits[0]) begin
                  emit          = 1'b1;
                  req_v.valid   = 1'b1;
                  req_v.literal = 1'b1;
                  phase_next    = (flags_left_next != '0) ? PH_ITEM : PH_CTRL;
                end else begin
                  first_ref_next = b;
                  phase_next     = PH_REF2;
                end
              end
              PH_REF2: begin
                second_ref_next = b;
                if (b[3:0] == lzss_pkg::NIB_EXT) begin
                  phase_next = PH_EXT1;
                end else begin
                  finish = 1'b1;
                  len    = 16'(b[3:0]) + lzss_pkg::LEN_BIAS;
                end
              end
              PH_EXT1: begin
                if (b[7]) begin
                  ext_low_next = b[6:0];
                  phase_next   = PH_EXT2;
                end else begin
                  finish = 1'b1;
                  len    = lzss_pkg::LEN_EXT + 16'(b);
                end
              end
              PH_EXT2: begin
                finish = 1'b1;
                len    = lzss_pkg::LEN_EXT + 16'({b, ext_low});
              end
              default: begin
                flag_bits_next  = b;
                flags_left_next = lzss_pkg::FLAG_CNT;
                phase_next      = PH_ITEM;
              end
            endcase
            if (finish) begin
              if (offset == lzss_pkg::OFS_END) begin
                stream_ended_next = 1'b1;
                phase_next        = PH_CTRL;
                req_v.valid       = 1'b1;
                req_v.status      = lzss_pkg::ST_END;
              end else begin
                copy_remaining_next = len;
                copy_distance_next  = offset;
                phase_next          = (flags_left_next != '0) ? PH_ITEM : PH_CTRL;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      wp_next = (wp == WP_LAST) ? '0 : wp + AW'(1);
      if (wp == WP_LAST) begin
        wrapped_next = 1'b1;
      end
    end else begin
      wp_next = wp;
    end
    prev_emit_next = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CTRL;
      flag_bits      <= '0;
      flags_left     <= '0;
      first_ref      <= '0;
      second_ref     <= '0;
      ext_low        <= '0;
      copy_remaining <= '0;
      copy_distance  <= '0;
      stream_ended   <= 1'b0;
      wp             <= '0;
      wrapped        <= 1'b0;
      prev_emit      <= 1'b0;
    end else begin
      phase          <= phase_next;
      flag_bits      <= flag_bits_next;
      flags_left     <= flags_left_next;
      first_ref      <= first_ref_next;
      second_ref     <= second_ref_next;
      ext_low        <= ext_low_next;
      copy_remaining <= copy_remaining_next;
      copy_distance  <= copy_distance_next;
      stream_ended   <= stream_ended_next;
      wp             <= wp_next;
      wrapped        <= wrapped_next;
      prev_emit      <= prev_emit_next;
    end
  end

  assign req     = req_v;
  assign rd_addr = src;
  assign wr_addr = wp;

endmodule

/* rtl/lzss_window.sv */
// History window memory with write-back stage and distance-one forwarding.
module lzss_window #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int AW = $clog2(WINDOW_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  lzss_pkg::win_req_t req,
  input  logic [AW-1:0]      rd_addr,
  input  logic [AW-1:0]      wr_addr,
  output logic               res_valid,
  output lzss_pkg::res_t     res
);

  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] mem_q;

  lzss_pkg::win_req_t s1;
  logic [AW-1:0]      s1_waddr;
  logic [7:0]         last_byte;
  logic [7:0]         byte_v;
  logic               wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= req.valid;
    end
    s1.literal  <= req.literal;
    s1.fwd      <= req.fwd;
    s1.rd_ok    <= req.rd_ok;
    s1.status   <= req.status;
    s1.lit_byte <= req.lit_byte;
    s1_waddr    <= wr_addr;
  end

  // Pick the byte: literal, forwarded previous byte, memory, or zero for unwritten history and non-byte beats.
  always_comb begin
    if (s1.status != lzss_pkg::ST_BYTE) begin
      byte_v = '0;
    end else if (s1.literal) begin
      byte_v = s1.lit_byte;
    end else if (s1.fwd) begin
      byte_v = last_byte;
    end else if (s1.rd_ok) begin
      byte_v = mem_q;
    end else begin
      byte_v = '0;
    end
  end

  assign wr_en = s1.valid && (s1.status == lzss_pkg::ST_BYTE);

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (wr_en) begin
      mem[s1_waddr] <= byte_v;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_byte <= byte_v;
    end
  end

  assign res_valid    = s1.valid;
  assign res.out_byte = byte_v;
  assign res.status   = s1.status;

endmodule

/* rtl/lzss_outq.sv */
// Three-entry result queue decoupling the window stage from the output channel.
module lzss_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lzss_pkg::res_t push_data,
  output logic [1:0]     count,
  output logic           res_valid,
  input  logic           res_ready,
  output lzss_pkg::res_t res
);

  localparam logic [1:0] LAST = 2'd2;

  lzss_pkg::res_t q [3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       pop;

  assign pop       = res_valid && res_ready;
  assign res_valid = (count != 2'd0);
  assign res       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? 2'd0 : rd_ptr + 2'd1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/lzss_stream_decompressor.sv */
// Top level of the LZSS stream decompressor.
// Throughput: one command beat per cycle, literals and copy ticks included; input
// stalls only while the result queue and the window stage together hold three beats.
// A result beat enters the window stage, with its window read, at the edge that accepts
// its command, and is then written into the result queue, from which it is offered.
// Reset clears parse state, write position and wrap flag; a wrap flag and the write
// position mark which window entries hold history, so others read 0 without a clear.
module lzss_stream_decompressor #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  lzss_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output lzss_pkg::res_t res
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  lzss_pkg::win_req_t req;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               win_valid;
  lzss_pkg::res_t     win_res;
  logic [1:0]         q_count;
  logic               accept;

  // Hold off unless the queue can take this beat even if nothing drains.
  assign cmd_ready = (3'(q_count) + 3'(win_valid)) <= 3'd2;
  assign accept    = cmd_valid && cmd_ready;

  lzss_parse #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .AW(AW)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .cmd(cmd),
    .req(req),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr)
  );

  lzss_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .AW(AW)
  ) u_window (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .res_valid(win_valid),
    .res(win_res)
  );

  lzss_outq u_outq (
    .clk(clk),
    .rst(rst),
    .push(win_valid),
    .push_data(win_res),
    .count(q_count),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

endmodule

/* bench/tb.sv */
// Self-checking testbench for the LZSS stream decompressor.
`timescale 1ns / 100ps

typedef enum logic [2:0] {
  PH_CTRL,
  PH_ITEM,
  PH_REF2,
  PH_EXT1,
  PH_EXT2
} parse_phase_t;

class decoder_board;
  logic [7:0]   hist [0:4095];
  logic [11:0]  wr_pos;
  parse_phase_t phase;
  logic [7:0]   flags;
  logic [3:0]   flags_left;
  logic [7:0]   ref_hi;
  logic [7:0]   ref_lo;
  logic [6:0]   ext_lo;
  logic [15:0]  copy_left;
  logic [11:0]  copy_dist;
  bit           ended;
  lzss_pkg::res_t due_results[$];
  int           errors;
  int           n_checked;
  int           n_bytes;
  int           n_ends;
  int           n_refused;

  function new();
    foreach (hist[i]) hist[i] = 8'h00;
    wr_pos = '0;
    errors = 0;
    n_checked = 0;
    n_bytes = 0;
    n_ends = 0;
    n_refused = 0;
    restart();
  endfunction

  // Window and write position survive a new stream.
  function void restart();
    phase = PH_CTRL;
    flags = '0;
    flags_left = '0;
    ref_hi = '0;
    ref_lo = '0;
    ext_lo = '0;
    copy_left = '0;
    copy_dist = '0;
    ended = 1'b0;
  endfunction

  function void push_due(logic [7:0] b, lzss_pkg::status_code_t st);
    lzss_pkg::res_t r;
    r.out_byte = b;
    r.status = st;
    due_results.push_back(r);
  endfunction

  function void emit_byte(logic [7:0] b);
    hist[wr_pos] = b;
    wr_pos = wr_pos + 12'd1;
    n_bytes++;
    push_due(b, lzss_pkg::ST_BYTE);
  endfunction

  function parse_phase_t next_item();
    return (flags_left != 0) ? PH_ITEM : PH_CTRL;
  endfunction

  function void close_ref(logic [15:0] len);
    logic [11:0] ofs;
    ofs = {ref_hi, ref_lo[7:4]};
    if (ofs == lzss_pkg::OFS_END) begin
      ended = 1'b1;
      phase = PH_CTRL;
      n_ends++;
      push_due(8'h00, lzss_pkg::ST_END);
    end else begin
      copy_left = len;
      copy_dist = ofs;
      phase = next_item();
    end
  endfunction

  function void feed_byte(logic [7:0] b);
    logic lit;
    if (ended || copy_left != 0) begin
      n_refused++;
      push_due(8'h00, lzss_pkg::ST_REFUSED);
      return;
    end
    case (phase)
      PH_CTRL: begin
        flags = b;
        flags_left = lzss_pkg::FLAG_CNT;
        phase = PH_ITEM;
      end
      PH_ITEM: begin
        lit = flags[0];
        flags = flags >> 1;
        flags_left = flags_left - 4'd1;
        if (lit) begin
          emit_byte(b);
          phase = next_item();
        end else begin
          ref_hi = b;
          phase = PH_REF2;
        end
      end
      PH_REF2: begin
        ref_lo = b;
        if (b[3:0] == lzss_pkg::NIB_EXT) phase = PH_EXT1;
        else close_ref(lzss_pkg::LEN_BIAS + {12'h000, b[3:0]});
      end
      PH_EXT1: begin
        if (b[7]) begin
          ext_lo = b[6:0];
          phase = PH_EXT2;
        end else begin
          close_ref(lzss_pkg::LEN_EXT + {8'h00, b});
        end
      end
      PH_EXT2: close_ref(lzss_pkg::LEN_EXT + {1'b0, b, ext_lo});
      default: ;
    endcase
  endfunction

  function void note_command(lzss_pkg::cmd_t c);
    logic [11:0] src;
    case (c.command)
      lzss_pkg::CMD_START: restart();
      lzss_pkg::CMD_TICK: begin
        if (copy_left != 0) begin
          src = wr_pos - copy_dist - 12'd1;
          copy_left = copy_left - 16'd1;
          emit_byte(hist[src]);
        end
      end
      lzss_pkg::CMD_FEED: feed_byte(c.data_byte);
      default: ;
    endcase
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_output(lzss_pkg::res_t got);
    lzss_pkg::res_t want;
    if (due_results.size() == 0) begin
      report($sformatf("unexpected beat: byte %h status %0d", got.out_byte, got.status));
      return;
    end
    want = due_results.pop_front();
    n_checked++;
    if (got.status != want.status)
      report($sformatf("result %0d: status %0d, want %0d", n_checked, got.status,
                       want.status));
    if (got.out_byte != want.out_byte)
      report($sformatf("result %0d: byte %h, want %h", n_checked, got.out_byte,
                       want.out_byte));
  endtask
endclass

module tb;
  localparam int LIMIT        = 1_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int ITEMS_TARGET = 1550;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  lzss_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  lzss_pkg::res_t res;

  decoder_board board = new();
  int tx_gap_max = 14;
  int rx_gap_max = 14;
  bit hold_req   = 1'b0;
  int n_items    = 0;
  int cycles     = 0;

  lzss_stream_decompressor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Sample at the edge, compare at the falling edge so the input side has noted its beat.
  always @(posedge clk) begin
    lzss_pkg::res_t got;
    if (!rst && res_valid && res_ready) begin
      got = res;
      @(negedge clk);
      board.check_output(got);
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      if ($urandom_range(0, 63) == 0) rx_gap_max = (rx_gap_max == 0) ? 14 : 0;
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] d);
    lzss_pkg::cmd_t c;
    int gap;
    c.command = op;
    c.data_byte = d;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    board.note_command(c);
    if (op != CMD_UNUSED) n_items++;
  endtask

  task automatic feed(input logic [7:0] b);
    send(lzss_pkg::CMD_FEED, b);
  endtask

  task automatic tick();
    send(lzss_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Pull out the pending copy; now and then offer a byte that must be refused.
  task automatic drain_copy();
    while (board.copy_left != 0) begin
      if ($urandom_range(0, 19) == 0) feed(8'($urandom_range(0, 255)));
      tick();
    end
  endtask

  task automatic put_ref(input logic [11:0] ofs, input logic [3:0] nib,
                         input logic [7:0] e1, input logic [7:0] e2);
    feed(ofs[11:4]);
    feed({ofs[3:0], nib});
    if (nib == lzss_pkg::NIB_EXT) begin
      feed(e1);
      if (e1[7]) feed(e2);
    end
    drain_copy();
  endtask

  task automatic rand_ref(input bit is_end, output bit aborted);
    logic [11:0] ofs;
    logic [3:0]  nib;
    logic [7:0]  e1;
    logic [7:0]  e2;
    int          sel;
    aborted = 1'b0;
    sel = $urandom_range(0, 9);
    if (is_end) ofs = lzss_pkg::OFS_END;
    else if (sel < 5) ofs = 12'($urandom_range(0, 15));
    else if (sel < 8) ofs = 12'($urandom_range(0, 255));
    else ofs = 12'($urandom_range(0, 12'hFFE));
    nib = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 2) != 0) e1 = 8'($urandom_range(0, 40));
    else e1 = 8'h80 | 8'($urandom_range(0, 127));
    e2 = ($urandom_range(0, 30) == 0) ? 8'($urandom_range(2, 3)) : 8'($urandom_range(0, 1));
    if (is_end) begin
      e1 = 8'($urandom_range(0, 255));
      e2 = 8'($urandom_range(0, 255));
    end
    // Break the reference after its first byte.
    if ($urandom_range(0, 49) == 0) begin
      feed(ofs[11:4]);
      send(lzss_pkg::CMD_START, 8'($urandom_range(0, 255)));
      aborted = 1'b1;
      return;
    end
    put_ref(ofs, nib, e1, e2);
  endtask

  task automatic play_items(input logic [7:0] ctrl, input int n, output bit aborted);
    aborted = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0)
        send($urandom_range(0, 1) ? CMD_UNUSED : lzss_pkg::CMD_TICK,
             8'($urandom_range(0, 255)));
      if ($urandom_range(0, 59) == 0) begin
        send(lzss_pkg::CMD_START, 8'($urandom_range(0, 255)));
        aborted = 1'b1;
        return;
      end
      if (ctrl[i]) begin
        feed(8'($urandom_range(0, 255)));
      end else begin
        rand_ref(1'b0, aborted);
        if (aborted) return;
      end
    end
  endtask

  task automatic gen_stream();
    logic [7:0] ctrl;
    int         pos;
    bit         aborted;
    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    send(lzss_pkg::CMD_START, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 3)) begin
      ctrl = 8'($urandom_range(0, 255));
      feed(ctrl);
      play_items(ctrl, 8, aborted);
      if (aborted) return;
    end
    if ($urandom_range(0, 1)) begin
      ctrl = 8'($urandom_range(0, 255));
      pos = $urandom_range(0, 7);
      ctrl[pos] = 1'b0;
      feed(ctrl);
      play_items(ctrl, pos, aborted);
      if (aborted) return;
      rand_ref(1'b1, aborted);
      if (aborted) return;
      feed(8'($urandom_range(0, 255)));
      tick();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle tick, unused command, then one short stream of literals, copies, an end marker and refused feeds.
    send(lzss_pkg::CMD_TICK, 8'h00);
    send(CMD_UNUSED, 8'hFF);
    send(lzss_pkg::CMD_START, 8'h00);
    feed(8'b0000_0011);
    feed(8'h00);
    feed(8'hFF);
    // Reaches before the first byte written, so copies zeros; the last feed is refused.
    feed(8'h10);
    feed(8'h00);
    feed(8'hAA);
    drain_copy();
    put_ref(12'h000, 4'h0, 8'h00, 8'h00);
    put_ref(lzss_pkg::OFS_END, 4'h0, 8'h00, 8'h00);
    feed(8'h55);
    tick();
    send(lzss_pkg::CMD_START, 8'h00);

    hold_req = 1'b1;
    while (n_items < ITEMS_TARGET) begin
      gen_stream();
    end
    cmd_valid <= 1'b0;

    while (board.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d command beats, %0d results checked (%0d bytes out, %0d end markers,",
             n_items, board.n_checked, board.n_bytes, board.n_ends);
    $display("  %0d refused feeds, window write position %0d), %0d mismatches",
             board.n_refused, board.wr_pos, board.errors);
    if (board.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
